// File: rtl/core/sc_bg_pkg.sv
package sc_bg_pkg;

    // store size and derived widths
    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // field widths
    localparam int SAMPLE_W    = 32;
    localparam int WORD_W      = SAMPLE_W + 1;
    localparam int K_W         = 12;
    localparam int OUT_CNT_W   = 11;
    localparam int CFG_IDX_W   = 1;

    // arithmetic widths
    localparam int SUM_W       = SAMPLE_W + CNT_W;
    localparam int MAG_W       = SAMPLE_W + 1;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int DIVD_W      = SQ_W + CNT_W;
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int BND_W       = SAMPLE_W + 8 + K_W + 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_K_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_K_LOWER = 1'b1;
    localparam logic [K_W-1:0]       K_RESET     = 12'd512;

    // job handed from the loader to the pass engine
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             ovf;
    } job_t;

    // store write request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } ram_wr_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SUM,
        B_DIVM,
        B_DIVM_WAIT,
        B_VAR,
        B_DIVV,
        B_DIVV_WAIT,
        B_SQRT,
        B_SQRT_WAIT,
        B_CHECK,
        B_CLIP,
        B_DONE
    } back_state_t;

endpackage

// File: rtl/core/sigma_clip_background.sv
// channel   | ports                                           | handshake
// ----------+-------------------------------------------------+------------------------
// request   | sample[31:0], last                              | start & !busy
// result    | background, std_dev, kept_count[10:0], status   | done, one cycle
// config    | cfg_index, cfg_data[11:0]                       | cfg_we, no wait
//
// samples load one a cycle while busy is low; a request with last closes the set and busy rises
// the time each pass takes grows with the kept set of n and is
// bounded by the serial divider (one bit a cycle) and the root unit
// rst_n clears the loader, queue and sequencer; the store itself needs no clearing
// results cannot be stalled: done is a single-cycle strobe
module sigma_clip_background (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sc_bg_pkg::SAMPLE_W-1:0]      sample,
    input  logic                                last,
    output logic                                done,
    output logic [sc_bg_pkg::SAMPLE_W-1:0]      background,
    output logic [sc_bg_pkg::ROOT_W-1:0]        std_dev,
    output logic [sc_bg_pkg::OUT_CNT_W-1:0]     kept_count,
    output logic                                status,
    input  logic                                cfg_we,
    input  logic [sc_bg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sc_bg_pkg::K_W-1:0]           cfg_data
);

    logic [sc_bg_pkg::K_W-1:0]      k_upper_reg;
    logic [sc_bg_pkg::K_W-1:0]      k_lower_reg;
    logic                           accept;
    logic                           push;
    logic                           q_not_empty;
    logic                           pop;
    logic                           back_active;
    sc_bg_pkg::job_t                push_job;
    sc_bg_pkg::job_t                head_job;
    sc_bg_pkg::ram_wr_t             front_wr;
    sc_bg_pkg::ram_wr_t             back_wr;
    sc_bg_pkg::ram_wr_t             ram_wr;
    logic [sc_bg_pkg::ADDR_W-1:0]   raddr;
    logic [sc_bg_pkg::WORD_W-1:0]   rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_upper_reg <= sc_bg_pkg::K_RESET;
            k_lower_reg <= sc_bg_pkg::K_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sc_bg_pkg::REG_K_UPPER: k_upper_reg <= cfg_data;
                sc_bg_pkg::REG_K_LOWER: k_lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request acceptance
    assign busy   = q_not_empty || back_active;
    assign accept = start && !busy;

    // store write: the engine owns the port while it runs
    assign ram_wr = back_wr.we ? back_wr : front_wr;

    sc_bg_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample),
        .last   (last),
        .wr     (front_wr),
        .push   (push),
        .job    (push_job)
    );

    sc_bg_jobq u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    sc_bg_ram #(
        .WIDTH (sc_bg_pkg::WORD_W),
        .DEPTH (sc_bg_pkg::MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    sc_bg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_not_empty),
        .job        (head_job),
        .job_pop    (pop),
        .k_upper    (k_upper_reg),
        .k_lower    (k_lower_reg),
        .raddr      (raddr),
        .rdata      (rdata),
        .wr         (back_wr),
        .active     (back_active),
        .done       (done),
        .background (background),
        .std_dev    (std_dev),
        .kept_count (kept_count),
        .status     (status)
    );

endmodule

// File: rtl/core/sc_bg_ram.sv
module sc_bg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/sc_bg_div.sv
module sc_bg_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sc_bg_pkg::DIVD_W-1:0]   dividend,
    input  logic [sc_bg_pkg::CNT_W-1:0]    divisor,
    output logic                           done,
    output logic [sc_bg_pkg::DIVD_W-1:0]   quotient
);

    localparam int DW    = sc_bg_pkg::DIVD_W;
    localparam int CW    = sc_bg_pkg::CNT_W;
    localparam int STP_W = $clog2(DW + 1);

    logic             run_reg;
    logic             done_reg;
    logic [STP_W-1:0] stp_reg;
    logic [CW-1:0]    rem_reg;
    logic [CW-1:0]    dvs_reg;
    logic [DW-1:0]    quo_reg;
    logic [CW:0]      rem_sh;
    logic             fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DW-1]};
        fits   = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            stp_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (stp_reg == STP_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                stp_reg <= STP_W'(DW);
            end
            else if (run_reg)
            begin
                stp_reg <= stp_reg - STP_W'(1);
                if (stp_reg == STP_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? CW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/sc_bg_sqrt.sv
module sc_bg_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sc_bg_pkg::RAD_W-1:0]   radicand,
    output logic                          done,
    output logic [sc_bg_pkg::ROOT_W-1:0]  root
);

    localparam int RW    = sc_bg_pkg::RAD_W;
    localparam int QW    = sc_bg_pkg::ROOT_W;
    localparam int REM_W = QW + 2;
    localparam int STP_W = $clog2(QW + 1);

    logic             run_reg;
    logic             done_reg;
    logic [STP_W-1:0] stp_reg;
    logic [RW-1:0]    rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [QW-1:0]    root_reg;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             fits;

    // one root bit per cycle from the top bit pair down
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RW-1:RW-2]};
        trial  = (REM_W + 2)'({root_reg, 2'b01});
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            stp_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (stp_reg == STP_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                stp_reg <= STP_W'(QW);
            end
            else if (run_reg)
            begin
                stp_reg <= stp_reg - STP_W'(1);
                if (stp_reg == STP_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[RW-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/core/sc_bg_front.sv
module sc_bg_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [sc_bg_pkg::SAMPLE_W-1:0]    sample,
    input  logic                              last,
    output sc_bg_pkg::ram_wr_t                wr,
    output logic                              push,
    output sc_bg_pkg::job_t                   job
);

    localparam int CW = sc_bg_pkg::CNT_W;

    logic [CW-1:0] lc_reg;
    logic [CW-1:0] lc_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          room;

    // store the sample while there is room, otherwise flag the drop
    always_comb
    begin
        room     = lc_reg < CW'(sc_bg_pkg::MAX_SAMPLES);
        lc_next  = lc_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (room)
            begin
                lc_next = lc_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        wr.we    = accept && room;
        wr.addr  = lc_reg[sc_bg_pkg::ADDR_W-1:0];
        wr.data  = {1'b1, sample};
        push     = accept && last;
        job.n    = lc_next;
        job.ovf  = ovf_next;
    end

    // set closes on a last request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (push)
        begin
            lc_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            lc_reg  <= lc_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

// File: rtl/core/sc_bg_jobq.sv
module sc_bg_jobq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sc_bg_pkg::job_t    push_job,
    input  logic               pop,
    output logic               not_empty,
    output sc_bg_pkg::job_t    head
);

    sc_bg_pkg::job_t slot_reg [2];
    logic            wp_reg;
    logic            rp_reg;
    logic [1:0]      fill_reg;

    // two-entry queue of closed sets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_job;
        end
    end

    assign not_empty = fill_reg != 2'd0;
    assign head      = slot_reg[rp_reg];

endmodule

// File: rtl/core/sc_bg_back.sv
module sc_bg_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_valid,
    input  sc_bg_pkg::job_t                    job,
    output logic                               job_pop,
    input  logic [sc_bg_pkg::K_W-1:0]          k_upper,
    input  logic [sc_bg_pkg::K_W-1:0]          k_lower,
    output logic [sc_bg_pkg::ADDR_W-1:0]       raddr,
    input  logic [sc_bg_pkg::WORD_W-1:0]       rdata,
    output sc_bg_pkg::ram_wr_t                 wr,
    output logic                               active,
    output logic                               done,
    output logic [sc_bg_pkg::SAMPLE_W-1:0]     background,
    output logic [sc_bg_pkg::ROOT_W-1:0]       std_dev,
    output logic [sc_bg_pkg::OUT_CNT_W-1:0]    kept_count,
    output logic                               status
);

    localparam int AW  = sc_bg_pkg::ADDR_W;
    localparam int CW  = sc_bg_pkg::CNT_W;
    localparam int SW  = sc_bg_pkg::SAMPLE_W;
    localparam int UW  = sc_bg_pkg::SUM_W;
    localparam int MW  = sc_bg_pkg::MAG_W;
    localparam int QW  = sc_bg_pkg::SQ_W;
    localparam int DW  = sc_bg_pkg::DIVD_W;
    localparam int RW  = sc_bg_pkg::RAD_W;
    localparam int TW  = sc_bg_pkg::ROOT_W;
    localparam int BW  = sc_bg_pkg::BND_W;
    localparam int KW  = sc_bg_pkg::K_W;

    sc_bg_pkg::back_state_t state_reg;
    sc_bg_pkg::back_state_t state_next;

    logic [CW-1:0]        n_reg;
    logic                 ovf_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        kept_reg;
    logic [CW-1:0]        rd_idx_reg;
    logic                 p1_v_reg;
    logic [AW-1:0]        p1_addr_reg;
    logic                 p2_v_reg;
    logic                 p3_v_reg;
    logic signed [MW:0]   d_reg;
    logic [QW-1:0]        sq_reg;
    logic signed [UW-1:0] sum_reg;
    logic [DW-1:0]        ss_reg;
    logic signed [SW-1:0] mean_reg;
    logic [TW-1:0]        sd_reg;
    logic [RW-1:0]        rad_reg;
    logic signed [BW-1:0] lo_reg;
    logic signed [BW-1:0] hi_reg;

    logic                 pass_state;
    logic                 issue;
    logic                 pass_end;
    logic                 keep_in;
    logic signed [SW-1:0] x_in;
    logic signed [BW-1:0] x256;
    logic                 keep_new;
    logic                 sum_neg;
    logic [UW-1:0]        sum_mag;
    logic [MW-1:0]        d_mag;
    logic [SW:0]          q_mag;
    logic [KW:0]          k_sum;
    logic signed [BW-1:0] mean256;
    logic                 div_start;
    logic [DW-1:0]        div_dvd;
    logic [CW-1:0]        div_dvs;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic                 sq_start;
    logic                 sq_done;
    logic [TW-1:0]        sq_root;

    sc_bg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    sc_bg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (rad_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    // pass sequencing over the store
    always_comb
    begin
        pass_state = (state_reg == sc_bg_pkg::B_SUM) || (state_reg == sc_bg_pkg::B_VAR)
                     || (state_reg == sc_bg_pkg::B_CLIP);
        issue      = pass_state && (rd_idx_reg < n_reg);
        pass_end   = pass_state && !issue && !p1_v_reg && !p2_v_reg && !p3_v_reg;
        keep_in    = rdata[SW];
        x_in       = $signed(rdata[SW-1:0]);
        x256       = BW'(x_in) <<< 8;
        mean256    = BW'(mean_reg) <<< 8;
        keep_new   = keep_in && (x256 >= lo_reg) && (x256 <= hi_reg);
        sum_neg    = sum_reg[UW-1];
        sum_mag    = sum_neg ? UW'(-sum_reg) : UW'(sum_reg);
        d_mag      = d_reg[MW] ? MW'(-d_reg) : MW'(d_reg);
        q_mag      = div_quo[SW:0];
        k_sum      = (KW + 1)'(k_lower) + (KW + 1)'(k_upper);
        div_dvd    = (state_reg == sc_bg_pkg::B_DIVM) ? DW'(sum_mag) : ss_reg;
        div_dvs    = (state_reg == sc_bg_pkg::B_DIVM) ? count_reg : count_reg - CW'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sc_bg_pkg::B_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = sc_bg_pkg::B_SUM;
                end
            end
            sc_bg_pkg::B_SUM:
            begin
                if (pass_end)
                begin
                    state_next = sc_bg_pkg::B_DIVM;
                end
            end
            sc_bg_pkg::B_DIVM:
            begin
                state_next = sc_bg_pkg::B_DIVM_WAIT;
            end
            sc_bg_pkg::B_DIVM_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (count_reg >= CW'(2)) ? sc_bg_pkg::B_VAR
                                                      : sc_bg_pkg::B_CHECK;
                end
            end
            sc_bg_pkg::B_VAR:
            begin
                if (pass_end)
                begin
                    state_next = sc_bg_pkg::B_DIVV;
                end
            end
            sc_bg_pkg::B_DIVV:
            begin
                state_next = sc_bg_pkg::B_DIVV_WAIT;
            end
            sc_bg_pkg::B_DIVV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = sc_bg_pkg::B_SQRT;
                end
            end
            sc_bg_pkg::B_SQRT:
            begin
                state_next = sc_bg_pkg::B_SQRT_WAIT;
            end
            sc_bg_pkg::B_SQRT_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = sc_bg_pkg::B_CHECK;
                end
            end
            sc_bg_pkg::B_CHECK:
            begin
                if (count_reg == '0 || k_sum == '0 || sd_reg == '0)
                begin
                    state_next = sc_bg_pkg::B_DONE;
                end
                else
                begin
                    state_next = sc_bg_pkg::B_CLIP;
                end
            end
            sc_bg_pkg::B_CLIP:
            begin
                if (pass_end)
                begin
                    state_next = (kept_reg == count_reg) ? sc_bg_pkg::B_DONE
                                                         : sc_bg_pkg::B_SUM;
                end
            end
            sc_bg_pkg::B_DONE:
            begin
                state_next = sc_bg_pkg::B_IDLE;
            end
            default:
            begin
                state_next = sc_bg_pkg::B_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        job_pop   = (state_reg == sc_bg_pkg::B_IDLE) && job_valid;
        div_start = (state_reg == sc_bg_pkg::B_DIVM) || (state_reg == sc_bg_pkg::B_DIVV);
        sq_start  = state_reg == sc_bg_pkg::B_SQRT;
        active    = state_reg != sc_bg_pkg::B_IDLE;
        done      = state_reg == sc_bg_pkg::B_DONE;
        raddr     = rd_idx_reg[AW-1:0];
        wr.we     = (state_reg == sc_bg_pkg::B_CLIP) && p1_v_reg;
        wr.addr   = p1_addr_reg;
        wr.data   = {keep_new, rdata[SW-1:0]};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sc_bg_pkg::B_IDLE;
            rd_idx_reg <= '0;
            p1_v_reg   <= 1'b0;
            p2_v_reg   <= 1'b0;
            p3_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= (pass_end || !pass_state) ? '0
                          : (issue ? rd_idx_reg + CW'(1) : rd_idx_reg);
            p1_v_reg   <= issue;
            p2_v_reg   <= p1_v_reg && keep_in && (state_reg == sc_bg_pkg::B_VAR);
            p3_v_reg   <= p2_v_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        p1_addr_reg <= rd_idx_reg[AW-1:0];
        d_reg       <= (MW + 1)'(x_in) - (MW + 1)'(mean_reg);
        sq_reg      <= QW'(d_mag) * QW'(d_mag);

        if (job_pop)
        begin
            n_reg     <= job.n;
            count_reg <= job.n;
            ovf_reg   <= job.ovf;
        end

        // kept sum
        if (state_reg == sc_bg_pkg::B_SUM)
        begin
            if (p1_v_reg && keep_in)
            begin
                sum_reg <= sum_reg + UW'(x_in);
            end
        end
        else if (state_reg == sc_bg_pkg::B_CLIP || state_reg == sc_bg_pkg::B_IDLE)
        begin
            sum_reg <= '0;
        end

        // squared deviations
        if (state_reg == sc_bg_pkg::B_SUM)
        begin
            ss_reg <= '0;
        end
        else if (state_reg == sc_bg_pkg::B_VAR && p3_v_reg)
        begin
            ss_reg <= ss_reg + DW'(sq_reg);
        end

        // mean, and zero deviation for small sets
        if (state_reg == sc_bg_pkg::B_DIVM_WAIT && div_done)
        begin
            mean_reg <= (count_reg == '0) ? '0
                        : SW'(sum_neg ? (SW + 1)'(-q_mag) : q_mag);
            if (count_reg < CW'(2))
            begin
                sd_reg <= '0;
            end
        end

        // saturate the variance quotient
        if (state_reg == sc_bg_pkg::B_DIVV_WAIT && div_done)
        begin
            rad_reg <= (div_quo[DW-1:RW] != '0) ? '1 : div_quo[RW-1:0];
        end

        if (state_reg == sc_bg_pkg::B_SQRT_WAIT && sq_done)
        begin
            sd_reg <= sq_root;
        end

        // window bounds
        if (state_reg == sc_bg_pkg::B_CHECK)
        begin
            lo_reg   <= mean256 - BW'(k_lower) * BW'(sd_reg);
            hi_reg   <= mean256 + BW'(k_upper) * BW'(sd_reg);
            kept_reg <= '0;
        end
        else if (state_reg == sc_bg_pkg::B_CLIP && p1_v_reg && keep_new)
        begin
            kept_reg <= kept_reg + CW'(1);
        end

        if (state_reg == sc_bg_pkg::B_CLIP && pass_end)
        begin
            count_reg <= kept_reg;
        end
    end

    assign background = mean_reg;
    assign std_dev    = sd_reg;
    assign kept_count = sc_bg_pkg::OUT_CNT_W'(count_reg);
    assign status     = ovf_reg;

endmodule

// File: verif/sigma_clip_background_test.sv
`default_nettype none

module sigma_clip_background_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sc_bg_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int TAIL_CYCLES   = 400;

    // one pending request: either a sample or a register write
    typedef struct {
        bit                    is_cfg;
        logic [SAMPLE_W-1:0]   smp;
        bit                    lst;
        logic [CFG_IDX_W-1:0]  idx;
        logic [K_W-1:0]        val;
    } drive_item_t;

    typedef struct {
        logic [SAMPLE_W-1:0]  bg;
        logic [ROOT_W-1:0]    sd;
        logic [OUT_CNT_W-1:0] cnt;
        logic                 ovf;
    } clip_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [SAMPLE_W-1:0] sample = '0;
    logic last = 1'b0;
    logic done;
    logic [SAMPLE_W-1:0] background;
    logic [ROOT_W-1:0] std_dev;
    logic [OUT_CNT_W-1:0] kept_count;
    logic status;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [K_W-1:0] cfg_data = '0;

    drive_item_t pending_reqs[$];
    clip_result_t expected_results[$];
    int mismatch_count = 0;
    int gap_left = 0;
    int quiet_cycles = 0;

    // shadow of the block's set and coefficients
    logic [SAMPLE_W-1:0] shadow_store[MAX_SAMPLES];
    bit shadow_keep[MAX_SAMPLES];
    int shadow_loaded = 0;
    bit shadow_ovf = 1'b0;
    logic [K_W-1:0] shadow_ku = K_RESET;
    logic [K_W-1:0] shadow_kl = K_RESET;

    always #6 clk = ~clk;

    sigma_clip_background u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample     (sample),
        .last       (last),
        .done       (done),
        .background (background),
        .std_dev    (std_dev),
        .kept_count (kept_count),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // iterative clipping over the loaded set
    function automatic clip_result_t clip_set();
        clip_result_t res;
        int cnt;
        int kept;
        longint sum;
        longint mean;
        longint dv;
        longint lo_b;
        longint hi_b;
        longint x;
        logic [127:0] sq_sum;
        logic [127:0] quot;
        logic [127:0] mag;
        logic [63:0] sd;
        cnt = shadow_loaded;
        mean = 0;
        sd = 0;
        forever
        begin
            sum = 0;
            sq_sum = 0;
            kept = 0;
            for (int i = 0; i < shadow_loaded; i++)
                if (shadow_keep[i])
                    sum += longint'($signed(shadow_store[i]));
            mean = (cnt > 0) ? sum / longint'(cnt) : 0;
            sd = 0;
            if (cnt >= 2)
            begin
                for (int i = 0; i < shadow_loaded; i++)
                    if (shadow_keep[i])
                    begin
                        dv = longint'($signed(shadow_store[i])) - mean;
                        mag = (dv < 0) ? 128'(-dv) : 128'(dv);
                        sq_sum += mag * mag;
                    end
                quot = sq_sum / 128'(cnt - 1);
                sd = isqrt64((quot[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quot[63:0]);
            end
            if (cnt == 0 || (64'(shadow_kl) + 64'(shadow_ku)) * sd == 0)
                break;
            lo_b = mean * 256 - longint'(64'(shadow_kl) * sd);
            hi_b = mean * 256 + longint'(64'(shadow_ku) * sd);
            for (int i = 0; i < shadow_loaded; i++)
                if (shadow_keep[i])
                begin
                    x = longint'($signed(shadow_store[i])) * 256;
                    if (x < lo_b || x > hi_b)
                        shadow_keep[i] = 1'b0;
                    else
                        kept++;
                end
            if (kept == cnt)
                break;
            cnt = kept;
        end
        res.bg = mean[31:0];
        res.sd = sd[31:0];
        res.cnt = cnt[OUT_CNT_W-1:0];
        res.ovf = shadow_ovf;
        return res;
    endfunction

    // load one accepted request and predict the result when the set closes
    task automatic load_request(logic [SAMPLE_W-1:0] smp, bit lst);
        clip_result_t res;
        if (shadow_loaded < MAX_SAMPLES)
        begin
            shadow_store[shadow_loaded] = smp;
            shadow_keep[shadow_loaded] = 1'b1;
            shadow_loaded++;
        end
        else
            shadow_ovf = 1'b1;
        if (lst)
        begin
            res = clip_set();
            expected_results = {expected_results, res};
            shadow_loaded = 0;
            shadow_ovf = 1'b0;
            for (int i = 0; i < MAX_SAMPLES; i++)
                shadow_keep[i] = 1'b1;
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_sample(logic [SAMPLE_W-1:0] smp, bit lst);
        drive_item_t it;
        it = '{is_cfg: 1'b0, smp: smp, lst: lst, idx: '0, val: '0};
        pending_reqs = {pending_reqs, it};
    endtask

    task automatic add_coeffs(logic [K_W-1:0] ku, logic [K_W-1:0] kl);
        drive_item_t it;
        it = '{is_cfg: 1'b1, smp: '0, lst: 1'b0, idx: REG_K_UPPER, val: ku};
        pending_reqs = {pending_reqs, it};
        it.idx = REG_K_LOWER;
        it.val = kl;
        pending_reqs = {pending_reqs, it};
    endtask

    // random set: a cluster with a few outliers, or wide random values
    task automatic add_random_set(int len);
        int centre;
        int spread;
        bit wide;
        logic [SAMPLE_W-1:0] v;
        centre = $urandom();
        spread = $urandom_range(0, 3) == 0 ? 0 : (1 << $urandom_range(0, 24));
        wide = $urandom_range(0, 4) == 0;
        for (int i = 0; i < len; i++)
        begin
            if (wide || $urandom_range(0, 9) == 0)
                v = $urandom();
            else
                v = centre + int'($urandom_range(0, 2 * spread)) - spread;
            add_sample(v, i == len - 1);
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        drive_item_t nxt;
        bit hold;
        bit n_start;
        bit n_we;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                load_request(sample, last);
                if (pending_reqs.size() > 150 && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 7);
            end
            hold = start && busy;
            n_start = hold;
            n_we = 1'b0;
            if (!hold)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0)
                begin
                    if (!pending_reqs[0].is_cfg)
                    begin
                        nxt = pending_reqs.pop_front();
                        n_start = 1'b1;
                        sample <= nxt.smp;
                        last <= nxt.lst;
                    end
                    else if (quiet_cycles >= SETTLE_CYCLES)
                    begin
                        nxt = pending_reqs.pop_front();
                        n_we = 1'b1;
                        cfg_index <= nxt.idx;
                        cfg_data <= nxt.val;
                        if (nxt.idx == REG_K_UPPER)
                            shadow_ku = nxt.val;
                        else
                            shadow_kl = nxt.val;
                    end
                end
            end
            if (!start && !busy && expected_results.size() == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            start <= n_start;
            cfg_we <= n_we;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        clip_result_t exp_r;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", {32'd0, background}, 64'd0);
            else
            begin
                exp_r = expected_results.pop_front();
                if (background !== exp_r.bg)
                    report_mismatch("background", 64'(background), 64'(exp_r.bg));
                if (std_dev !== exp_r.sd)
                    report_mismatch("std_dev", 64'(std_dev), 64'(exp_r.sd));
                if (kept_count !== exp_r.cnt)
                    report_mismatch("kept_count", 64'(kept_count), 64'(exp_r.cnt));
                if (status !== exp_r.ovf)
                    report_mismatch("status", 64'(status), 64'(exp_r.ovf));
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        // directed sets under the reset coefficients
        add_sample(32'h1234_5678, 1'b1);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h8000_0000, 1'b1);
        add_sample(32'hFFFF_FFFF, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 7; i++)
            add_sample(32'd100 + i, 1'b0);
        add_sample(32'h4000_0000, 1'b1);
        // both coefficients zero: the set is not clipped
        add_coeffs(12'd0, 12'd0);
        add_sample(32'd5, 1'b0);
        add_sample(-32'sd5, 1'b1);
        // every sample clipped away
        add_coeffs(12'd1, 12'd0);
        add_sample(-32'sd1000, 1'b0);
        add_sample(32'd1000, 1'b1);
        add_coeffs(12'd4095, 12'd4095);
        add_sample(32'h0000_0000, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h8000_0000, 1'b1);
        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: add_coeffs(12'd512, 12'd512);
                1: add_coeffs(12'd0, 12'd4095);
                2: add_coeffs(12'd4095, 12'd0);
                3: add_coeffs(12'd256, 12'd256);
                default: add_coeffs(12'($urandom_range(64, 4095)),
                                    12'($urandom_range(64, 4095)));
            endcase
            if (ph == 0)
                add_random_set(1030);
            for (int s = 0; s < 10; s++)
                add_random_set($urandom_range(1, 16));
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #200ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
